>>> rtl/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg
// Shared types and constants of the alarm clock controller.
// ----------------------------------------------------------------------------
package acc_pkg;

    localparam int UNIT_W = 32;

    localparam logic [3:0] SLOT_NONE  = 4'd8;
    localparam logic [5:0] GUARD_NONE = 6'd63;

    localparam logic [UNIT_W-1:0] MIN_PER_HOUR  = 32'd60;
    localparam logic [UNIT_W-1:0] HOURS_PER_DAY = 32'd24;

    localparam logic [19:0] RING_TIMEOUT_RST = 20'd60000;
    localparam logic [15:0] STEP0_RST        = 16'd100;
    localparam logic [15:0] STEP1_RST        = 16'd100;
    localparam logic [15:0] STEP2_RST        = 16'd100;
    localparam logic [15:0] STEP3_RST        = 16'd500;
    localparam logic [3:0]  TONE_MASK_RST    = 4'd5;

    typedef enum logic [2:0] {
        CFG_RING_TIMEOUT = 3'd0,
        CFG_STEP0        = 3'd1,
        CFG_STEP1        = 3'd2,
        CFG_STEP2        = 3'd3,
        CFG_STEP3        = 3'd4,
        CFG_TONE_MASK    = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_DISMISS = 2'd1,
        ACT_SNOOZE  = 2'd2,
        ACT_WRITE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RINGING = 2'd1,
        MODE_SNOOZED = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE        = 2'd0,
        EV_SHOW_ALARM  = 2'd1,
        EV_SHOW_SNOOZE = 2'd2,
        EV_HIDE        = 2'd3
    } event_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_STEP_DIFF,
        ST_STEP_CMP,
        ST_RING_DIFF,
        ST_RING_CMP,
        ST_SNZ_MIN,
        ST_SNZ_HOUR,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       enabled;
        logic [4:0] hour;
        logic [5:0] minute;
    } slot_entry_t;

    typedef struct packed {
        logic [UNIT_W-1:0] diff;
        logic              borrow;
        logic              zero;
    } unit_res_t;

endpackage

>>> rtl/acc_sub_unit.sv
// ----------------------------------------------------------------------------
// acc_sub_unit
// Shared subtract and compare unit: difference, borrow and zero flag.
// ----------------------------------------------------------------------------
module acc_sub_unit
    import acc_pkg::*;
(
    input  logic [UNIT_W-1:0] op_a,
    input  logic [UNIT_W-1:0] op_b,
    output unit_res_t         res
);

    logic [UNIT_W:0] full_diff;

    assign full_diff  = {1'b0, op_a} - {1'b0, op_b};
    assign res.diff   = full_diff[UNIT_W-1:0];
    assign res.borrow = full_diff[UNIT_W];
    assign res.zero   = (full_diff[UNIT_W-1:0] == '0);

endmodule

>>> rtl/acc_slot_table.sv
// ----------------------------------------------------------------------------
// acc_slot_table
// Alarm slot table with per-slot same-minute retrigger guards.
// ----------------------------------------------------------------------------
module acc_slot_table
    import acc_pkg::*;
#(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tbl_wr_en,
    input  logic [IDX_W-1:0] tbl_wr_idx,
    input  slot_entry_t      tbl_wr_entry,
    input  logic             grd_wr_en,
    input  logic [5:0]       grd_wr_val,
    input  logic [IDX_W-1:0] rd_idx,
    output slot_entry_t      rd_entry,
    output logic [5:0]       rd_guard
);

    slot_entry_t entry_reg [SLOTS];
    logic [5:0]  guard_reg [SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                entry_reg[i] <= '0;
                guard_reg[i] <= GUARD_NONE;
            end
        end else begin
            if (tbl_wr_en) begin
                entry_reg[tbl_wr_idx] <= tbl_wr_entry;
            end
            if (grd_wr_en) begin
                guard_reg[rd_idx] <= grd_wr_val;
            end
        end
    end

    assign rd_entry = entry_reg[rd_idx];
    assign rd_guard = guard_reg[rd_idx];

endmodule

>>> rtl/alarm_clock_controller_top.sv
// ----------------------------------------------------------------------------
// alarm_clock_controller_top
// Alarm controller: slot table scan, snooze, buzzer pattern and timeout.
// ----------------------------------------------------------------------------
// Input beats arrive on s_t*: s_tuser carries the action (tick, dismiss,
// snooze, slot write), s_tdata the time, millisecond count and slot fields.
// Each accepted beat yields exactly one result beat on m_t*.
// A small sequencer drives one shared 32-bit subtract/compare unit:
//   tick while ringing : two modular differences, two compares
//   tick otherwise     : one slot per cycle through the table, stopping at
//                        a match or after the last slot
//   snooze             : iterative mod-60 and mod-24 steps
//   dismiss, write     : handled in the dispatch state alone
// s_tready is high only while no beat is in work; it rises again in the
// cycle after a result is loaded into the output register.
// The output register holds a result until m_tready takes it; a new beat
// may be accepted and worked meanwhile, and its result waits for the slot.
// Reset (aresetn low, synchronous) restores the register defaults, disables
// all slots, clears the guards and leaves the block idle with no result.
// Configuration writes (cfg_wr_en) take effect at once and are meant for
// idle periods; indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module alarm_clock_controller_top
    import acc_pkg::*;
#(
    parameter int ALARM_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // hour_now, cur_minute, now_ms, snooze_len, slot, alarm_hour,
    // alarm_minute, alarm_enabled, zero fill
    input  logic [71:0] s_tdata,
    // action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // buzz_on, popup_event, popup_hour, popup_minute, popup_slot,
    // alarm_mode, ringing_slot, any_enabled
    output logic [23:0] m_tdata
);

    localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_SLOTS - 1);

    state_t state_reg, state_next;

    action_t     act_reg;
    logic [4:0]  ch_reg;
    logic [5:0]  cm_reg;
    logic [31:0] now_reg;
    logic [7:0]  snz_reg;
    logic [2:0]  wslot_reg;
    slot_entry_t wentry_reg;

    logic [19:0] timeout_reg;
    logic [15:0] step_ms_reg [4];
    logic [3:0]  tone_mask_reg;

    mode_t       mode_reg, mode_next;
    logic [3:0]  cur_slot_reg, cur_slot_next;
    logic        snz_pend_reg, snz_pend_next;
    logic [4:0]  snz_hour_reg, snz_hour_next;
    logic [5:0]  snz_min_reg, snz_min_next;
    logic [31:0] ring_start_reg, ring_start_next;
    logic [1:0]  pat_step_reg, pat_step_next;
    logic [31:0] step_start_reg, step_start_next;
    logic        buzzer_reg, buzzer_next;
    logic        seen_reg, seen_next;

    event_t      ev_reg, ev_next;
    logic [4:0]  ph_reg, ph_next;
    logic [5:0]  pm_reg, pm_next;
    logic [2:0]  ps_reg, ps_next;
    logic [31:0] diff_reg, diff_next;
    logic [8:0]  min_acc_reg, min_acc_next;
    logic [5:0]  hr_acc_reg, hr_acc_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;

    logic [UNIT_W-1:0] op_a, op_b;
    unit_res_t         unit_res;

    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_idx;
    logic             grd_wr_en;
    logic [5:0]       grd_wr_val;
    slot_entry_t      rd_entry;
    logic [5:0]       rd_guard;

    logic s_accept;
    logic [1:0] next_step;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign next_step = pat_step_reg + 2'd1;

    acc_sub_unit u_unit (
        .op_a (op_a),
        .op_b (op_b),
        .res  (unit_res)
    );

    acc_slot_table #(
        .SLOTS (ALARM_SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tbl_wr_en    (tbl_wr_en),
        .tbl_wr_idx   (tbl_wr_idx),
        .tbl_wr_entry (wentry_reg),
        .grd_wr_en    (grd_wr_en),
        .grd_wr_val   (grd_wr_val),
        .rd_idx       (scan_idx_reg),
        .rd_entry     (rd_entry),
        .rd_guard     (rd_guard)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg           <= action_t'(s_tuser);
            ch_reg            <= s_tdata[4:0];
            cm_reg            <= s_tdata[10:5];
            now_reg           <= s_tdata[42:11];
            snz_reg           <= s_tdata[50:43];
            wslot_reg         <= s_tdata[53:51];
            wentry_reg.hour   <= s_tdata[58:54];
            wentry_reg.minute <= s_tdata[64:59];
            wentry_reg.enabled <= s_tdata[65];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= RING_TIMEOUT_RST;
            step_ms_reg[0] <= STEP0_RST;
            step_ms_reg[1] <= STEP1_RST;
            step_ms_reg[2] <= STEP2_RST;
            step_ms_reg[3] <= STEP3_RST;
            tone_mask_reg  <= TONE_MASK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RING_TIMEOUT: timeout_reg    <= cfg_data;
                CFG_STEP0:        step_ms_reg[0] <= cfg_data[15:0];
                CFG_STEP1:        step_ms_reg[1] <= cfg_data[15:0];
                CFG_STEP2:        step_ms_reg[2] <= cfg_data[15:0];
                CFG_STEP3:        step_ms_reg[3] <= cfg_data[15:0];
                CFG_TONE_MASK:    tone_mask_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_IDLE;
            cur_slot_reg   <= SLOT_NONE;
            snz_pend_reg   <= 1'b0;
            snz_hour_reg   <= '0;
            snz_min_reg    <= '0;
            ring_start_reg <= '0;
            pat_step_reg   <= '0;
            step_start_reg <= '0;
            buzzer_reg     <= 1'b0;
            seen_reg       <= 1'b0;
            scan_idx_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            cur_slot_reg   <= cur_slot_next;
            snz_pend_reg   <= snz_pend_next;
            snz_hour_reg   <= snz_hour_next;
            snz_min_reg    <= snz_min_next;
            ring_start_reg <= ring_start_next;
            pat_step_reg   <= pat_step_next;
            step_start_reg <= step_start_next;
            buzzer_reg     <= buzzer_next;
            seen_reg       <= seen_next;
            scan_idx_reg   <= scan_idx_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg      <= ev_next;
        ph_reg      <= ph_next;
        pm_reg      <= pm_next;
        ps_reg      <= ps_next;
        diff_reg    <= diff_next;
        min_acc_reg <= min_acc_next;
        hr_acc_reg  <= hr_acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        unique case (state_reg)
            ST_STEP_DIFF: begin
                op_a = now_reg;
                op_b = step_start_reg;
            end
            ST_STEP_CMP: begin
                op_a = diff_reg;
                op_b = UNIT_W'(step_ms_reg[pat_step_reg]);
            end
            ST_RING_DIFF: begin
                op_a = now_reg;
                op_b = ring_start_reg;
            end
            ST_RING_CMP: begin
                op_a = UNIT_W'(timeout_reg);
                op_b = diff_reg;
            end
            ST_SNZ_MIN: begin
                op_a = UNIT_W'(min_acc_reg);
                op_b = MIN_PER_HOUR;
            end
            ST_SNZ_HOUR: begin
                op_a = UNIT_W'(hr_acc_reg);
                op_b = HOURS_PER_DAY;
            end
            ST_SCAN: begin
                op_a = UNIT_W'({rd_entry.hour, rd_entry.minute});
                op_b = UNIT_W'({ch_reg, cm_reg});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cur_slot_next   = cur_slot_reg;
        snz_pend_next   = snz_pend_reg;
        snz_hour_next   = snz_hour_reg;
        snz_min_next    = snz_min_reg;
        ring_start_next = ring_start_reg;
        pat_step_next   = pat_step_reg;
        step_start_next = step_start_reg;
        buzzer_next     = buzzer_reg;
        seen_next       = seen_reg;
        ev_next         = ev_reg;
        ph_next         = ph_reg;
        pm_next         = pm_reg;
        ps_next         = ps_reg;
        diff_next       = diff_reg;
        min_acc_next    = min_acc_reg;
        hr_acc_next     = hr_acc_reg;
        scan_idx_next   = scan_idx_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        tbl_wr_en       = 1'b0;
        tbl_wr_idx      = IDX_W'(32'(wslot_reg));
        grd_wr_en       = 1'b0;
        grd_wr_val      = GUARD_NONE;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                ev_next    = EV_NONE;
                ph_next    = '0;
                pm_next    = '0;
                ps_next    = '0;
                state_next = ST_DONE;
                unique case (act_reg)
                    ACT_TICK: begin
                        if (mode_reg == MODE_RINGING) begin
                            state_next = ST_STEP_DIFF;
                        end else if (snz_pend_reg && ch_reg == snz_hour_reg &&
                                     cm_reg == snz_min_reg) begin
                            snz_pend_next   = 1'b0;
                            mode_next       = MODE_RINGING;
                            ring_start_next = now_reg;
                            ev_next         = EV_SHOW_SNOOZE;
                            ph_next         = snz_hour_reg;
                            pm_next         = snz_min_reg;
                        end else begin
                            seen_next     = 1'b0;
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                    end
                    ACT_DISMISS: begin
                        if (mode_reg != MODE_IDLE) begin
                            buzzer_next   = 1'b0;
                            mode_next     = MODE_IDLE;
                            cur_slot_next = SLOT_NONE;
                            snz_pend_next = 1'b0;
                            ev_next       = EV_HIDE;
                        end
                    end
                    ACT_SNOOZE: begin
                        if (mode_reg == MODE_RINGING) begin
                            min_acc_next = 9'(cm_reg) + 9'(snz_reg);
                            hr_acc_next  = 6'(ch_reg);
                            state_next   = ST_SNZ_MIN;
                        end
                    end
                    ACT_WRITE: begin
                        tbl_wr_en = (32'(wslot_reg) < ALARM_SLOTS);
                    end
                endcase
            end
            ST_STEP_DIFF: begin
                diff_next  = unit_res.diff;
                state_next = ST_STEP_CMP;
            end
            ST_STEP_CMP: begin
                if (!unit_res.borrow) begin
                    step_start_next = now_reg;
                    pat_step_next   = next_step;
                    buzzer_next     = tone_mask_reg[next_step];
                end
                state_next = ST_RING_DIFF;
            end
            ST_RING_DIFF: begin
                diff_next  = unit_res.diff;
                state_next = ST_RING_CMP;
            end
            ST_RING_CMP: begin
                if (unit_res.borrow) begin
                    buzzer_next   = 1'b0;
                    mode_next     = MODE_IDLE;
                    cur_slot_next = SLOT_NONE;
                    snz_pend_next = 1'b0;
                    ev_next       = EV_HIDE;
                end
                state_next = ST_DONE;
            end
            ST_SNZ_MIN: begin
                if (!unit_res.borrow) begin
                    min_acc_next = unit_res.diff[8:0];
                    hr_acc_next  = hr_acc_reg + 6'd1;
                end else begin
                    state_next = ST_SNZ_HOUR;
                end
            end
            ST_SNZ_HOUR: begin
                if (!unit_res.borrow) begin
                    hr_acc_next = unit_res.diff[5:0];
                end else begin
                    snz_hour_next = hr_acc_reg[4:0];
                    snz_min_next  = min_acc_reg[5:0];
                    snz_pend_next = 1'b1;
                    buzzer_next   = 1'b0;
                    mode_next     = MODE_SNOOZED;
                    ev_next       = EV_HIDE;
                    state_next    = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
                if (rd_entry.enabled) begin
                    seen_next = 1'b1;
                    if (rd_guard != cm_reg) begin
                        grd_wr_en = 1'b1;
                        if (unit_res.zero) begin
                            grd_wr_val      = cm_reg;
                            cur_slot_next   = 4'(scan_idx_reg);
                            mode_next       = MODE_RINGING;
                            ring_start_next = now_reg;
                            ev_next         = EV_SHOW_ALARM;
                            ph_next         = rd_entry.hour;
                            pm_next         = rd_entry.minute;
                            ps_next         = 3'(scan_idx_reg);
                            state_next      = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {seen_reg, cur_slot_reg, mode_reg, ps_reg,
                                     pm_reg, ph_reg, ev_reg, buzzer_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sim/alarm_clock_checker.sv
// ----------------------------------------------------------------------------
// alarm_clock_checker
// Watches the configuration port and both stream channels of the alarm clock
// controller, keeps its own copy of the slot table, guards, snooze and buzzer
// state, predicts one result beat per accepted input beat and compares every
// result beat field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
package acc_beat_pkg;
    import acc_pkg::*;

    typedef struct packed {
        logic [5:0]  fill;
        logic        alarm_enabled;
        logic [5:0]  alarm_minute;
        logic [4:0]  alarm_hour;
        logic [2:0]  slot;
        logic [7:0]  snooze_len;
        logic [31:0] now_ms;
        logic [5:0]  cur_minute;
        logic [4:0]  hour_now;
    } in_beat_t;

    typedef struct packed {
        logic       any_enabled;
        logic [3:0] ringing_slot;
        mode_t      alarm_mode;
        logic [2:0] popup_slot;
        logic [5:0] popup_minute;
        logic [4:0] popup_hour;
        event_t     popup_event;
        logic       buzz_on;
    } out_beat_t;
endpackage

module alarm_clock_checker import acc_pkg::*, acc_beat_pkg::*; #(
    parameter int ALARM_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          results_due,
    output int          results_checked,
    output int          alarms_shown
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [19:0] timeout_ms;
    logic [15:0] step_len [4];
    logic [3:0]  tone_bits;

    slot_entry_t slots [ALARM_SLOTS];
    logic [5:0]  guard [ALARM_SLOTS];
    mode_t       mode;
    logic [3:0]  cur_slot;
    logic        snz_pending;
    logic [4:0]  snz_hour;
    logic [5:0]  snz_minute;
    logic [31:0] ring_start;
    logic [31:0] step_start;
    logic [1:0]  step_idx;
    logic        buzzer;
    logic        seen_enabled;

    out_beat_t   due_results [$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_alarm_state();
        int i;
        timeout_ms  = RING_TIMEOUT_RST;
        step_len[0] = STEP0_RST;
        step_len[1] = STEP1_RST;
        step_len[2] = STEP2_RST;
        step_len[3] = STEP3_RST;
        tone_bits   = TONE_MASK_RST;
        for (i = 0; i < ALARM_SLOTS; i++) begin
            slots[i] = '0;
            guard[i] = GUARD_NONE;
        end
        mode         = MODE_IDLE;
        cur_slot     = SLOT_NONE;
        snz_pending  = 1'b0;
        snz_hour     = '0;
        snz_minute   = '0;
        ring_start   = '0;
        step_start   = '0;
        step_idx     = '0;
        buzzer       = 1'b0;
        seen_enabled = 1'b0;
        due_results.delete();
    endtask

    function automatic void drop_to_idle(inout event_t ev);
        if (mode != MODE_IDLE) begin
            buzzer      = 1'b0;
            mode        = MODE_IDLE;
            cur_slot    = SLOT_NONE;
            snz_pending = 1'b0;
            ev          = EV_HIDE;
        end
    endfunction

    task automatic advance_alarm(input action_t act, input in_beat_t b, output out_beat_t r);
        int          i;
        int unsigned total;
        bit          fired;
        logic [31:0] elapsed;
        event_t      ev;
        logic [4:0]  ph;
        logic [5:0]  pm;
        logic [2:0]  ps;
        ev    = EV_NONE;
        ph    = '0;
        pm    = '0;
        ps    = '0;
        fired = 1'b0;
        case (act)
            ACT_TICK: begin
                if (mode == MODE_RINGING) begin
                    elapsed = b.now_ms - step_start;
                    if (elapsed >= {16'd0, step_len[step_idx]}) begin
                        step_start = b.now_ms;
                        step_idx   = step_idx + 2'd1;
                        buzzer     = tone_bits[step_idx];
                    end
                    elapsed = b.now_ms - ring_start;
                    if (elapsed > {12'd0, timeout_ms})
                        drop_to_idle(ev);
                end else if (snz_pending && b.hour_now == snz_hour
                             && b.cur_minute == snz_minute) begin
                    snz_pending = 1'b0;
                    mode        = MODE_RINGING;
                    ring_start  = b.now_ms;
                    ev          = EV_SHOW_SNOOZE;
                    ph          = snz_hour;
                    pm          = snz_minute;
                end else begin
                    seen_enabled = 1'b0;
                    for (i = 0; i < ALARM_SLOTS && !fired; i++) begin
                        if (slots[i].enabled) begin
                            seen_enabled = 1'b1;
                            if (guard[i] != b.cur_minute) begin
                                if (slots[i].hour == b.hour_now
                                    && slots[i].minute == b.cur_minute) begin
                                    guard[i]   = b.cur_minute;
                                    cur_slot   = 4'(i);
                                    mode       = MODE_RINGING;
                                    ring_start = b.now_ms;
                                    ev         = EV_SHOW_ALARM;
                                    ph         = slots[i].hour;
                                    pm         = slots[i].minute;
                                    ps         = 3'(i);
                                    fired      = 1'b1;
                                end else begin
                                    guard[i] = GUARD_NONE;
                                end
                            end
                        end
                    end
                end
            end
            ACT_DISMISS: drop_to_idle(ev);
            ACT_SNOOZE: begin
                if (mode == MODE_RINGING) begin
                    total       = b.hour_now * 60 + b.cur_minute + b.snooze_len;
                    snz_hour    = 5'((total / 60) % 24);
                    snz_minute  = 6'(total % 60);
                    snz_pending = 1'b1;
                    buzzer      = 1'b0;
                    mode        = MODE_SNOOZED;
                    ev          = EV_HIDE;
                end
            end
            ACT_WRITE: begin
                if (int'(b.slot) < ALARM_SLOTS)
                    slots[b.slot] = '{b.alarm_enabled, b.alarm_hour, b.alarm_minute};
            end
        endcase
        r = '{any_enabled: seen_enabled, ringing_slot: cur_slot, alarm_mode: mode,
              popup_slot: ps, popup_minute: pm, popup_hour: ph, popup_event: ev,
              buzz_on: buzzer};
    endtask

    always @(posedge aclk) begin : monitor
        out_beat_t got;
        out_beat_t want;
        if (!aresetn) begin
            clear_alarm_state();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RING_TIMEOUT: timeout_ms  = cfg_data;
                    CFG_STEP0:        step_len[0] = cfg_data[15:0];
                    CFG_STEP1:        step_len[1] = cfg_data[15:0];
                    CFG_STEP2:        step_len[2] = cfg_data[15:0];
                    CFG_STEP3:        step_len[3] = cfg_data[15:0];
                    CFG_TONE_MASK:    tone_bits   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_alarm(action_t'(s_tuser), s_tdata, want);
                due_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", m_tdata, 0);
                end else begin
                    want = due_results.pop_front();
                    if (got.buzz_on != want.buzz_on)
                        report_mismatch("buzz_on", got.buzz_on, want.buzz_on);
                    if (got.popup_event != want.popup_event)
                        report_mismatch("popup_event", got.popup_event, want.popup_event);
                    if (got.popup_hour != want.popup_hour)
                        report_mismatch("popup_hour", got.popup_hour, want.popup_hour);
                    if (got.popup_minute != want.popup_minute)
                        report_mismatch("popup_minute", got.popup_minute, want.popup_minute);
                    if (got.popup_slot != want.popup_slot)
                        report_mismatch("popup_slot", got.popup_slot, want.popup_slot);
                    if (got.alarm_mode != want.alarm_mode)
                        report_mismatch("alarm_mode", got.alarm_mode, want.alarm_mode);
                    if (got.ringing_slot != want.ringing_slot)
                        report_mismatch("ringing_slot", got.ringing_slot, want.ringing_slot);
                    if (got.any_enabled != want.any_enabled)
                        report_mismatch("any_enabled", got.any_enabled, want.any_enabled);
                    results_checked++;
                    if (want.popup_event == EV_SHOW_ALARM)
                        alarms_shown++;
                end
            end
        end
        results_due <= due_results.size();
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the alarm clock controller with a short directed sequence and then
// random alarm sessions (slot writes, matching ticks, ringing with a moving
// millisecond count, snooze, dismiss, timeout) mixed with random beats,
// under four register settings and four flow-control phases.
// ----------------------------------------------------------------------------
module testbench import acc_pkg::*, acc_beat_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RUN_BEATS   = 550;
    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [2:0] CFG_SPARE   = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;

    int fail_count;
    int results_due;
    int results_checked;
    int alarms_shown;
    int sender_idle_pct;
    int receiver_stall_pct;
    int beats_sent;
    int cycle_count;
    int directed_beats;

    logic [31:0] clock_ms;
    logic [19:0] ring_limit_ms;

    alarm_clock_controller_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alarm_clock_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .results_due    (results_due),
        .results_checked(results_checked),
        .alarms_shown   (alarms_shown)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_beat(input action_t act, input in_beat_t b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [19:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [19:0] timeout, input logic [15:0] s0,
                                 input logic [15:0] s1, input logic [15:0] s2,
                                 input logic [15:0] s3, input logic [3:0] mask);
        put_reg(CFG_RING_TIMEOUT, timeout);
        put_reg(CFG_STEP0, {4'($urandom), s0});
        put_reg(CFG_STEP1, {4'($urandom), s1});
        put_reg(CFG_STEP2, {4'($urandom), s2});
        put_reg(CFG_STEP3, {4'($urandom), s3});
        put_reg(CFG_TONE_MASK, {16'($urandom), mask});
        put_reg(CFG_SPARE, 20'($urandom));
        cfg_wr_en     <= 1'b0;
        ring_limit_ms = timeout;
    endtask

    function automatic in_beat_t noise_beat();
        in_beat_t b;
        b      = 72'({$urandom, $urandom, $urandom});
        b.fill = '0;
        return b;
    endfunction

    function automatic void step_clock();
        case ($urandom_range(9))
            0:       clock_ms = $urandom;
            1, 2:    clock_ms += $urandom_range(70000);
            default: clock_ms += $urandom_range(700);
        endcase
    endfunction

    task automatic tick_at(input logic [4:0] h, input logic [5:0] m);
        in_beat_t b;
        b            = noise_beat();
        b.hour_now   = h;
        b.cur_minute = m;
        b.now_ms     = clock_ms;
        send_beat(ACT_TICK, b);
    endtask

    task automatic send_dismiss();
        send_beat(ACT_DISMISS, noise_beat());
    endtask

    task automatic snooze_for(input logic [4:0] h, input logic [5:0] m, input logic [7:0] mins);
        in_beat_t b;
        b            = noise_beat();
        b.hour_now   = h;
        b.cur_minute = m;
        b.now_ms     = clock_ms;
        b.snooze_len = mins;
        send_beat(ACT_SNOOZE, b);
    endtask

    task automatic write_slot(input logic [2:0] s, input logic [4:0] h, input logic [5:0] m,
                              input logic en);
        in_beat_t b;
        b               = noise_beat();
        b.slot          = s;
        b.alarm_hour    = h;
        b.alarm_minute  = m;
        b.alarm_enabled = en;
        send_beat(ACT_WRITE, b);
    endtask

    task automatic alarm_session();
        logic [2:0]  s;
        logic [4:0]  h;
        logic [4:0]  sh;
        logic [5:0]  m;
        logic [5:0]  sm;
        logic [7:0]  mins;
        int unsigned total;
        s = 3'($urandom_range(7));
        h = 5'($urandom_range(23));
        m = 6'($urandom_range(59));
        write_slot(s, h, m, 1'b1);
        if ($urandom_range(1))
            write_slot(3'($urandom_range(7)), 5'($urandom_range(23)),
                       6'($urandom_range(59)), 1'($urandom));
        if ($urandom_range(3) != 0) begin
            step_clock();
            tick_at(h, m ^ 6'd1);
        end
        step_clock();
        tick_at(h, m);
        repeat ($urandom_range(1, 6)) begin
            step_clock();
            tick_at(h, m);
        end
        case ($urandom_range(3))
            0: send_dismiss();
            1: begin
                mins  = 8'($urandom_range(255));
                snooze_for(h, m, mins);
                total = h * 60 + m + mins;
                sh    = 5'((total / 60) % 24);
                sm    = 6'(total % 60);
                if ($urandom_range(2) == 0) begin
                    write_slot(s ^ 3'd1, h, m ^ 6'd2, 1'b1);
                    step_clock();
                    tick_at(h, m ^ 6'd2);
                end
                step_clock();
                tick_at(sh, sm);
                step_clock();
                tick_at(sh, sm);
                if ($urandom_range(1))
                    send_dismiss();
                else
                    snooze_for(sh, sm, 8'($urandom_range(255)));
            end
            2: begin
                clock_ms += ring_limit_ms + $urandom_range(1, 50);
                tick_at(h, m);
            end
            default: ;
        endcase
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle actions, extreme slots, wrap, snooze past midnight, guard, timeout
        clock_ms = 32'hFFFF_FF00;
        tick_at(5'd0, 6'd0);
        send_dismiss();
        snooze_for(5'd0, 6'd0, 8'd0);
        write_slot(3'd7, 5'd23, 6'd59, 1'b1);
        write_slot(3'd0, 5'd0, 6'd0, 1'b1);
        tick_at(5'd23, 6'd59);
        clock_ms = 32'h0000_0010;
        tick_at(5'd23, 6'd59);
        tick_at(5'd23, 6'd59);
        snooze_for(5'd23, 6'd59, 8'd255);
        tick_at(5'd4, 6'd14);
        send_dismiss();
        tick_at(5'd23, 6'd59);
        tick_at(5'd0, 6'd0);
        snooze_for(5'd0, 6'd0, 8'd10);
        snooze_for(5'd0, 6'd0, 8'd10);
        write_slot(3'd2, 5'd0, 6'd5, 1'b1);
        tick_at(5'd0, 6'd5);
        send_dismiss();
        tick_at(5'd0, 6'd10);
        send_dismiss();
        write_slot(3'd0, 5'd0, 6'd0, 1'b0);
        write_slot(3'd3, 5'd31, 6'd63, 1'b1);
        tick_at(5'd31, 6'd63);
        tick_at(5'd31, 6'd63);
        clock_ms += 32'd60001;
        tick_at(5'd0, 6'd5);
        directed_beats = beats_sent;
        drain_results();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    load_settings(20'd600000, 16'd0, 16'd0, 16'd0, 16'd0, 4'hF);
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                end
                1: begin
                    load_settings(20'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h0);
                    sender_idle_pct = 68; receiver_stall_pct = 0;
                end
                2: begin
                    load_settings(20'($urandom_range(200, 5000)), 16'($urandom_range(400)),
                                  16'($urandom_range(400)), 16'($urandom_range(400)),
                                  16'($urandom_range(400)), 4'($urandom));
                    sender_idle_pct = 0;  receiver_stall_pct = 68;
                end
                default: begin
                    load_settings(RING_TIMEOUT_RST, STEP0_RST, STEP1_RST, STEP2_RST,
                                  STEP3_RST, TONE_MASK_RST);
                    sender_idle_pct = 6;  receiver_stall_pct = 6;
                end
            endcase
            for (int half = 0; half < 2; half++) begin
                while (beats_sent < directed_beats + (2 * p + half + 1) * RUN_BEATS / 8) begin
                    if ($urandom_range(3) == 0)
                        send_beat(action_t'($urandom_range(3)), noise_beat());
                    else
                        alarm_session();
                end
                drain_results();
            end
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (20) @(posedge aclk);
        $display("Covered %0d beats, %0d results checked, %0d alarm popups, across four",
                 beats_sent, results_checked, alarms_shown);
        $display("timeout and buzzer pattern settings under four flow-control phases.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
